// File: hdl/custom_radix_string_to_int_unit_assert.svh
`ifndef CUSTOM_RADIX_STRING_TO_INT_UNIT_ASSERT_SVH
`define CUSTOM_RADIX_STRING_TO_INT_UNIT_ASSERT_SVH

// same-cycle implication
`define CRSI_ASSERT_NOW(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CRSI_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/crsi_pkg.sv
`default_nettype none

package crsi_pkg;

  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 64;
  localparam int SYM_COUNT = 16;
  localparam int DIGIT_W   = 4;
  localparam int RADIX_W   = 5;
  localparam int MAG_W     = 31;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] INT_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_BASE = 2'd1,
    ST_BAD_CHAR = 2'd2,
    ST_SAT      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_SYMBOLS_LOW      = 2'd0,
    REG_SYMBOLS_HIGH     = 2'd1,
    REG_ALPHABET_LENGTH  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_mark;
  } req_t;

  typedef struct packed {
    logic signed [31:0] parsed_value;
    status_t            parse_status;
  } res_t;

  typedef struct packed {
    logic [SYM_COUNT-1:0][7:0] symbols;
    logic [RADIX_W-1:0]        radix;
    logic                      base_valid;
  } cfg_t;

  typedef struct packed {
    logic               hit;
    logic [DIGIT_W-1:0] digit;
  } lookup_t;

endpackage

`default_nettype wire

// File: hdl/crsi_cfg.sv
`default_nettype none

module crsi_cfg
  import crsi_pkg::*;
#(
  parameter int MAX_RADIX = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output cfg_t                   cfg
);

  logic [DATA_W-1:0]  symbols_low, symbols_low_next;
  logic [DATA_W-1:0]  symbols_high, symbols_high_next;
  logic [RADIX_W-1:0] alphabet_length, alphabet_length_next;
  logic               base_valid, base_valid_next;
  logic [SYM_COUNT-1:0][7:0] syms_next;
  cfg_reg_t           sel;
  logic               wr;

  assign sel = cfg_reg_t'(paddr[ADDR_W-1:3]);
  assign wr  = psel && penable && pwrite;

  always_comb begin
    symbols_low_next     = symbols_low;
    symbols_high_next    = symbols_high;
    alphabet_length_next = alphabet_length;
    if (wr) begin
      unique case (sel)
        REG_SYMBOLS_LOW:     symbols_low_next     = pwdata;
        REG_SYMBOLS_HIGH:    symbols_high_next    = pwdata;
        REG_ALPHABET_LENGTH: alphabet_length_next = pwdata[RADIX_W-1:0];
        default: ;
      endcase
    end
  end

  // base check from next values so it is current as soon as the write lands
  assign syms_next = {symbols_high_next, symbols_low_next};

  always_comb begin
    base_valid_next = (alphabet_length_next >= RADIX_W'(2)) &&
                      (alphabet_length_next <= RADIX_W'(MAX_RADIX));
    for (int i = 0; i < MAX_RADIX; i++) begin
      if (RADIX_W'(i) < alphabet_length_next) begin
        if (syms_next[i] == CHAR_PLUS || syms_next[i] == CHAR_MINUS)
          base_valid_next = 1'b0;
        for (int j = i + 1; j < MAX_RADIX; j++) begin
          if (RADIX_W'(j) < alphabet_length_next && syms_next[j] == syms_next[i])
            base_valid_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbols_low     <= '0;
      symbols_high    <= '0;
      alphabet_length <= '0;
      base_valid      <= 1'b0;
    end else begin
      symbols_low     <= symbols_low_next;
      symbols_high    <= symbols_high_next;
      alphabet_length <= alphabet_length_next;
      base_valid      <= base_valid_next;
    end
  end

  always_comb begin
    unique case (sel)
      REG_SYMBOLS_LOW:     prdata = symbols_low;
      REG_SYMBOLS_HIGH:    prdata = symbols_high;
      REG_ALPHABET_LENGTH: prdata = DATA_W'(alphabet_length);
      default:             prdata = '0;
    endcase
  end

  assign cfg.symbols    = {symbols_high, symbols_low};
  assign cfg.radix      = alphabet_length;
  assign cfg.base_valid = base_valid;

endmodule

`default_nettype wire

// File: hdl/crsi_lookup.sv
`default_nettype none

module crsi_lookup
  import crsi_pkg::*;
#(
  parameter int MAX_RADIX = 16
) (
  input  wire logic [7:0] char_code,
  input  wire cfg_t       cfg,
  output lookup_t         look
);

  logic [MAX_RADIX-1:0] match;

  always_comb begin
    for (int i = 0; i < MAX_RADIX; i++)
      match[i] = (RADIX_W'(i) < cfg.radix) && (cfg.symbols[i] == char_code);
  end

  // lowest matching position wins
  always_comb begin
    look.hit   = |match;
    look.digit = '0;
    for (int i = MAX_RADIX - 1; i >= 0; i--) begin
      if (match[i])
        look.digit = DIGIT_W'(i);
    end
  end

endmodule

`default_nettype wire

// File: hdl/custom_radix_string_to_int_unit.sv
// A request is registered into held_req on acceptance and processed from there;
// an end request's result is then registered into res.
// Throughput: one request per cycle; only an end request stalled behind an
// unread result holds the input register.
// Reset (synchronous, active high) clears config, parse state and the valids.
`default_nettype none

module custom_radix_string_to_int_unit
  import crsi_pkg::*;
#(
  parameter int MAX_RADIX = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire req_t              req,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output res_t                   res
);

  cfg_t    cfg;
  lookup_t look;

  logic               held, held_next;
  req_t               held_req;
  logic               advance, take, work;

  logic [MAG_W-1:0]   magnitude, magnitude_next;
  logic               negative, negative_next;
  logic               past_first_char, past_first_char_next;
  status_t            sticky_status, sticky_status_next;

  logic               res_valid_next;
  res_t               res_next;

  logic [MAG_W+RADIX_W-1:0] scaled;
  logic [MAG_W:0]           sum;
  status_t                  final_status;

  assign pready = 1'b1;

  crsi_cfg #(.MAX_RADIX(MAX_RADIX)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  crsi_lookup #(.MAX_RADIX(MAX_RADIX)) u_lookup (
    .char_code (held_req.char_code),
    .cfg       (cfg),
    .look      (look)
  );

  // only an end request needs the result slot
  assign advance   = !held_req.end_mark || !res_valid || !res_stall;
  assign req_stall = held && !advance;
  assign take      = req_valid && !req_stall;
  assign work      = held && advance;

  always_comb begin
    if (take)
      held_next = 1'b1;
    else if (advance)
      held_next = 1'b0;
    else
      held_next = held;
  end

  assign scaled = (MAG_W+RADIX_W)'(magnitude) * (MAG_W+RADIX_W)'(cfg.radix);
  assign sum    = scaled[MAG_W:0] + (MAG_W+1)'(look.digit);

  assign final_status = cfg.base_valid ? sticky_status : ST_BAD_BASE;

  always_comb begin
    magnitude_next       = magnitude;
    negative_next        = negative;
    past_first_char_next = past_first_char;
    sticky_status_next   = sticky_status;
    res_next             = res;
    res_valid_next       = res_valid && res_stall;

    if (work) begin
      if (held_req.end_mark) begin
        res_valid_next        = 1'b1;
        res_next.parse_status = final_status;
        case (final_status)
          ST_OK:   res_next.parsed_value = negative ? -$signed({1'b0, magnitude})
                                                    : $signed({1'b0, magnitude});
          ST_SAT:  res_next.parsed_value = negative ? INT_MIN : INT_MAX;
          default: res_next.parsed_value = '0;
        endcase
        magnitude_next       = '0;
        negative_next        = 1'b0;
        past_first_char_next = 1'b0;
        sticky_status_next   = ST_OK;
      end else if (sticky_status != ST_OK) begin
        sticky_status_next = sticky_status;
      end else if (!cfg.base_valid) begin
        sticky_status_next = ST_BAD_BASE;
      end else if (!past_first_char &&
                   (held_req.char_code == CHAR_PLUS || held_req.char_code == CHAR_MINUS)) begin
        negative_next        = (held_req.char_code == CHAR_MINUS);
        past_first_char_next = 1'b1;
      end else begin
        past_first_char_next = 1'b1;
        if (|scaled[MAG_W+RADIX_W-1:MAG_W])
          sticky_status_next = ST_SAT;
        else if (!look.hit)
          sticky_status_next = ST_BAD_CHAR;
        else if (sum[MAG_W])
          sticky_status_next = ST_SAT;
        else
          magnitude_next = sum[MAG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held            <= 1'b0;
      res_valid       <= 1'b0;
      magnitude       <= '0;
      negative        <= 1'b0;
      past_first_char <= 1'b0;
      sticky_status   <= ST_OK;
    end else begin
      held            <= held_next;
      res_valid       <= res_valid_next;
      magnitude       <= magnitude_next;
      negative        <= negative_next;
      past_first_char <= past_first_char_next;
      sticky_status   <= sticky_status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take)
      held_req <= req;
    res <= res_next;
  end

`include "custom_radix_string_to_int_unit_assert.svh"

  `CRSI_ASSERT_NEXT(a_end_gives_result, clk, rst, work && held_req.end_mark, res_valid, "end request produced no result")
  `CRSI_ASSERT_NEXT(a_end_clears_state, clk, rst, work && held_req.end_mark, magnitude == '0 && !negative && !past_first_char && sticky_status == ST_OK, "parse state not cleared after end")
  `CRSI_ASSERT_NOW(a_error_value_zero, clk, rst, res_valid && (res.parse_status == ST_BAD_BASE || res.parse_status == ST_BAD_CHAR), res.parsed_value == '0, "error result carries a nonzero value")
  `CRSI_ASSERT_NEXT(a_sticky_holds_mag, clk, rst, work && !held_req.end_mark && sticky_status != ST_OK, $stable(magnitude) && $stable(sticky_status), "state moved after a sticky status")

endmodule

`default_nettype wire
